[rtl/lprb_pkg.sv]
// Package for the length-prefixed byte ring: sizes, command and status codes,
// controller operation codes and the structs shared by the controller, datapath and top level.
// Depends on nothing.
package lprb_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int PTR_W        = $clog2(RING_BYTES);
    localparam int SIZE_W       = $clog2(RING_BYTES + 1);
    localparam int CFG_W        = 13;
    localparam int LEN_W        = 12;
    localparam int BYTE_W       = 8;
    localparam int CALC_W       = (SIZE_W > LEN_W + 1) ? SIZE_W : LEN_W + 1;
    localparam int PREFIX_BYTES = 4;
    localparam int MIN_RING     = 8;
    localparam logic [CFG_W-1:0] RING_SIZE_RESET = 13'd4096;

    localparam logic [1:0] CMD_APP_START = 2'd0;
    localparam logic [1:0] CMD_APP_BYTE  = 2'd1;
    localparam logic [1:0] CMD_GET_START = 2'd2;
    localparam logic [1:0] CMD_GET_BYTE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_CORRUPT = 3'd3;
    localparam logic [2:0] ST_TOO_BIG = 3'd4;
    localparam logic [2:0] ST_NO_OPEN = 3'd5;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_FULL      = 4'd1;
    localparam logic [3:0] OP_NO_OPEN   = 4'd2;
    localparam logic [3:0] OP_EMPTY     = 4'd3;
    localparam logic [3:0] OP_CORRUPT   = 4'd4;
    localparam logic [3:0] OP_APP_START = 4'd5;
    localparam logic [3:0] OP_PFX_WRITE = 4'd6;
    localparam logic [3:0] OP_APP_BYTE  = 4'd7;
    localparam logic [3:0] OP_GET_START = 4'd8;
    localparam logic [3:0] OP_PFX_READ  = 4'd9;
    localparam logic [3:0] OP_TOO_BIG   = 4'd10;
    localparam logic [3:0] OP_GET_OPEN  = 4'd11;
    localparam logic [3:0] OP_GET_BYTE  = 4'd12;
    localparam logic [3:0] OP_BYTE_OUT  = 4'd13;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [LEN_W-1:0]  msg_len;
        logic [LEN_W-1:0]  max_len;
        logic [BYTE_W-1:0] data_in;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [LEN_W-1:0]  length_out;
        logic [BYTE_W-1:0] data_out;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [3:0] op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       fits;
        logic       used_zero;
        logic       used_lt4;
        logic       app_left_zero;
        logic       rd_left_zero;
        logic       idx_last;
        logic       pfx_corrupt;
        logic       pfx_too_big;
        logic       res_busy;
    } dp_status_t;

endpackage

[rtl/lprb_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module lprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lprb_ctrl.sv]
// Controller state machine for the length-prefixed byte ring.
// Depends on lprb_pkg; drives the datapath through ctrl_cmd_t.
module lprb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  lprb_pkg::dp_status_t  stat,
    output lprb_pkg::ctrl_cmd_t   ctrl
);
    import lprb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WPFX  = 3'd1;
    localparam logic [2:0] S_RPFX  = 3'd2;
    localparam logic [2:0] S_RCHK  = 3'd3;
    localparam logic [2:0] S_RBYTE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready = (state_reg == S_IDLE) && !stat.res_busy;

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !stat.res_busy)
                begin
                    case (stat.cmd)
                        CMD_APP_START:
                        begin
                            if (stat.fits)
                            begin
                                ctrl.op    = OP_APP_START;
                                state_next = S_WPFX;
                            end
                            else
                            begin
                                ctrl.op = OP_FULL;
                            end
                        end
                        CMD_APP_BYTE:
                        begin
                            ctrl.op = stat.app_left_zero ? OP_NO_OPEN : OP_APP_BYTE;
                        end
                        CMD_GET_START:
                        begin
                            if (stat.used_zero)
                            begin
                                ctrl.op = OP_EMPTY;
                            end
                            else if (stat.used_lt4)
                            begin
                                ctrl.op = OP_CORRUPT;
                            end
                            else
                            begin
                                ctrl.op    = OP_GET_START;
                                state_next = S_RPFX;
                            end
                        end
                        default:
                        begin
                            if (stat.rd_left_zero)
                            begin
                                ctrl.op = OP_NO_OPEN;
                            end
                            else
                            begin
                                ctrl.op    = OP_GET_BYTE;
                                state_next = S_RBYTE;
                            end
                        end
                    endcase
                end
            end
            S_WPFX:
            begin
                ctrl.op = OP_PFX_WRITE;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RPFX:
            begin
                ctrl.op = OP_PFX_READ;
                if (stat.idx_last)
                begin
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (stat.pfx_corrupt)
                begin
                    ctrl.op = OP_CORRUPT;
                end
                else if (stat.pfx_too_big)
                begin
                    ctrl.op = OP_TOO_BIG;
                end
                else
                begin
                    ctrl.op = OP_GET_OPEN;
                end
                state_next = S_IDLE;
            end
            S_RBYTE:
            begin
                ctrl.op    = OP_BYTE_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/lprb_dp.sv]
// Datapath for the length-prefixed byte ring: pointers, counters, ring RAM,
// result staging and output register. Depends on lprb_pkg and lprb_ram.
module lprb_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lprb_pkg::ctrl_cmd_t       ctrl,
    output lprb_pkg::dp_status_t      stat,
    input  lprb_pkg::item_t           item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output lprb_pkg::result_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lprb_pkg::CFG_W-1:0] cfg_data
);
    import lprb_pkg::*;

    logic [CFG_W-1:0]    ring_size_reg, ring_size_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    pend_wr_reg, pend_wr_next;
    logic [PTR_W-1:0]    pend_rd_reg, pend_rd_next;
    logic [LEN_W-1:0]    app_left_reg, app_left_next;
    logic [LEN_W-1:0]    rd_left_reg, rd_left_next;
    logic [PTR_W-1:0]    work_ptr_reg, work_ptr_next;
    logic [1:0]          idx_reg, idx_next;
    logic [3*BYTE_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0]    msg_len_reg, msg_len_next;
    logic [LEN_W-1:0]    max_len_reg, max_len_next;
    result_t             res_reg, res_next, res_new;
    logic                res_valid_reg, res_valid_next, res_we;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next, move;

    logic [CALC_W-1:0]   rs_ext;
    logic [SIZE_W-1:0]   eff_size, used, free_bytes;
    logic [PTR_W-1:0]    work_adv, pend_wr_adv, pend_rd_adv;
    logic [LEN_W-1:0]    pfx_len;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata, pfx_byte;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] q;
        q = SIZE_W'(p) + SIZE_W'(1);
        return (q >= s) ? '0 : PTR_W'(q);
    endfunction

    lprb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rs_ext   = CALC_W'(ring_size_reg);
    assign eff_size = (rs_ext < CALC_W'(MIN_RING))   ? SIZE_W'(MIN_RING)   :
                      (rs_ext > CALC_W'(RING_BYTES)) ? SIZE_W'(RING_BYTES) :
                      SIZE_W'(rs_ext);

    always_comb
    begin
        if (rd_ptr_reg == wr_ptr_reg)
        begin
            used = '0;
        end
        else if (rd_ptr_reg < wr_ptr_reg)
        begin
            used = SIZE_W'(wr_ptr_reg) - SIZE_W'(rd_ptr_reg);
        end
        else
        begin
            used = eff_size - SIZE_W'(rd_ptr_reg) + SIZE_W'(wr_ptr_reg);
        end
    end

    assign free_bytes  = eff_size - used - SIZE_W'(1);
    assign work_adv    = adv(work_ptr_reg, eff_size);
    assign pend_wr_adv = adv(pend_wr_reg, eff_size);
    assign pend_rd_adv = adv(pend_rd_reg, eff_size);
    assign pfx_len     = len_reg[LEN_W-1:0];

    assign stat.cmd           = item.cmd;
    assign stat.fits          = (CALC_W'(item.msg_len) + CALC_W'(PREFIX_BYTES))
                                <= CALC_W'(free_bytes);
    assign stat.used_zero     = (used == '0);
    assign stat.used_lt4      = (CALC_W'(used) < CALC_W'(PREFIX_BYTES));
    assign stat.app_left_zero = (app_left_reg == '0);
    assign stat.rd_left_zero  = (rd_left_reg == '0);
    assign stat.idx_last      = (idx_reg == 2'd3);
    assign stat.pfx_corrupt   = (len_reg[3*BYTE_W-1:LEN_W] != '0) || (ram_rdata != '0)
                                || ((CALC_W'(pfx_len) + CALC_W'(PREFIX_BYTES))
                                    > CALC_W'(used));
    assign stat.pfx_too_big   = (pfx_len > max_len_reg);
    assign stat.res_busy      = res_valid_reg;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign ram_raddr    = (ctrl.op == OP_GET_BYTE) ? pend_rd_reg : work_ptr_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    pfx_byte = msg_len_reg[BYTE_W-1:0];
            2'd1:    pfx_byte = BYTE_W'(msg_len_reg[LEN_W-1:BYTE_W]);
            default: pfx_byte = '0;
        endcase
    end

    always_comb
    begin
        ring_size_next = ring_size_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        pend_wr_next   = pend_wr_reg;
        pend_rd_next   = pend_rd_reg;
        app_left_next  = app_left_reg;
        rd_left_next   = rd_left_reg;
        work_ptr_next  = work_ptr_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        msg_len_next   = msg_len_reg;
        max_len_next   = max_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = work_ptr_reg;
        ram_wdata      = pfx_byte;
        res_we         = 1'b0;
        res_new        = '0;
        res_new.status = ST_OK;

        case (ctrl.op)
            OP_FULL:
            begin
                res_we         = 1'b1;
                res_new.status = ST_FULL;
            end
            OP_NO_OPEN:
            begin
                res_we         = 1'b1;
                res_new.status = ST_NO_OPEN;
            end
            OP_EMPTY:
            begin
                rd_left_next   = '0;
                res_we         = 1'b1;
                res_new.status = ST_EMPTY;
            end
            OP_CORRUPT:
            begin
                rd_left_next   = '0;
                rd_ptr_next    = wr_ptr_reg;
                res_we         = 1'b1;
                res_new.status = ST_CORRUPT;
            end
            OP_APP_START:
            begin
                msg_len_next  = item.msg_len;
                work_ptr_next = wr_ptr_reg;
                idx_next      = 2'd0;
            end
            OP_PFX_WRITE:
            begin
                ram_we        = 1'b1;
                work_ptr_next = work_adv;
                idx_next      = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    pend_wr_next  = work_adv;
                    app_left_next = msg_len_reg;
                    res_we        = 1'b1;
                    if (msg_len_reg == '0)
                    begin
                        wr_ptr_next  = work_adv;
                        res_new.last = 1'b1;
                    end
                end
            end
            OP_APP_BYTE:
            begin
                ram_we        = 1'b1;
                ram_waddr     = pend_wr_reg;
                ram_wdata     = item.data_in;
                pend_wr_next  = pend_wr_adv;
                app_left_next = app_left_reg - LEN_W'(1);
                res_we        = 1'b1;
                if (app_left_reg == LEN_W'(1))
                begin
                    wr_ptr_next  = pend_wr_adv;
                    res_new.last = 1'b1;
                end
            end
            OP_GET_START:
            begin
                rd_left_next  = '0;
                max_len_next  = item.max_len;
                work_ptr_next = rd_ptr_reg;
                idx_next      = 2'd0;
            end
            OP_PFX_READ:
            begin
                work_ptr_next = work_adv;
                idx_next      = idx_reg + 2'd1;
                if (idx_reg != 2'd0)
                begin
                    len_next = {ram_rdata, len_reg[3*BYTE_W-1:BYTE_W]};
                end
            end
            OP_TOO_BIG:
            begin
                res_we             = 1'b1;
                res_new.status     = ST_TOO_BIG;
                res_new.length_out = pfx_len;
            end
            OP_GET_OPEN:
            begin
                res_we             = 1'b1;
                res_new.length_out = pfx_len;
                pend_rd_next       = work_ptr_reg;
                rd_left_next       = pfx_len;
                if (pfx_len == '0)
                begin
                    rd_ptr_next  = work_ptr_reg;
                    res_new.last = 1'b1;
                end
            end
            OP_BYTE_OUT:
            begin
                res_we           = 1'b1;
                res_new.data_out = ram_rdata;
                pend_rd_next     = pend_rd_adv;
                rd_left_next     = rd_left_reg - LEN_W'(1);
                if (rd_left_reg == LEN_W'(1))
                begin
                    rd_ptr_next  = pend_rd_adv;
                    res_new.last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_valid)
        begin
            ring_size_next = cfg_data;
            rd_ptr_next    = '0;
            wr_ptr_next    = '0;
            pend_wr_next   = '0;
            pend_rd_next   = '0;
            app_left_next  = '0;
            rd_left_next   = '0;
        end
    end

    // advance the staged result into the output register when it is free
    always_comb
    begin
        move           = !out_valid_reg || result_ready;
        out_valid_next = move ? res_valid_reg : out_valid_reg;
        out_next       = (move && res_valid_reg) ? res_reg : out_reg;
        res_valid_next = (res_valid_reg && !move) || res_we;
        res_next       = res_we ? res_new : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= RING_SIZE_RESET;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            pend_wr_reg   <= '0;
            pend_rd_reg   <= '0;
            app_left_reg  <= '0;
            rd_left_reg   <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ring_size_reg <= ring_size_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            pend_wr_reg   <= pend_wr_next;
            pend_rd_reg   <= pend_rd_next;
            app_left_reg  <= app_left_next;
            rd_left_reg   <= rd_left_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_ptr_reg <= work_ptr_next;
        len_reg      <= len_next;
        msg_len_reg  <= msg_len_next;
        max_len_reg  <= max_len_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

[rtl/length_prefixed_byte_ring.sv]
// Top level of the length-prefixed byte ring: controller plus datapath.
// Depends on lprb_pkg, lprb_ctrl and lprb_dp (which holds lprb_ram).
//
//   channel  | signals                              | payload
//   ---------+--------------------------------------+------------------
//   item     | item_valid, item_ready, item         | lprb_pkg::item_t
//   result   | result_valid, result_ready, result   | lprb_pkg::result_t
//   cfg      | cfg_valid, cfg_ready, cfg_data       | ring_size, 13 bits
//
// Transaction steps: append_byte and every command refused without a memory
// access (full, empty, short ring, no open message) finish from idle; get_byte
// reads its byte and returns it from a second state; append_start writes the
// four prefix bytes, and get_start reads them and then checks the length.
// Reset empties the ring at once; the store itself is not cleared.
// A stalled result waits in the output register while the next item is worked.
module length_prefixed_byte_ring (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  lprb_pkg::item_t            item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output lprb_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lprb_pkg::CFG_W-1:0] cfg_data
);
    import lprb_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    lprb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    lprb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

endmodule
